// ----- rtl/csd_pkg.sv -----
// ----------------------------------------------------------------------------
// csd_pkg
// Shared constants, types and helpers of the CAN signal decoder.
// ----------------------------------------------------------------------------
package csd_pkg;

  localparam int MESSAGE_ENTRIES = 64;
  localparam int FIELD_ENTRIES   = 256;
  localparam int SLICE_ENTRIES   = 256;
  localparam int MAX_LINKS       = 16;
  localparam int RESULT_LIMIT    = 16;

  localparam int MSG_AW = (MESSAGE_ENTRIES > 1) ? $clog2(MESSAGE_ENTRIES) : 1;
  localparam int FLD_AW = (FIELD_ENTRIES > 1) ? $clog2(FIELD_ENTRIES) : 1;
  localparam int SLC_AW = (SLICE_ENTRIES > 1) ? $clog2(SLICE_ENTRIES) : 1;
  localparam int MSG_CW = $clog2(MESSAGE_ENTRIES + 1);

  localparam int MSG_W = 48;
  localparam int FLD_W = 79;
  localparam int SLC_W = 19;

  localparam int IN_W  = 208;
  localparam int OUT_W = 80;

  typedef enum logic [1:0] {
    MODE_FRAME = 2'd0,
    MODE_MSG   = 2'd1,
    MODE_FIELD = 2'd2,
    MODE_SLICE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_BOOL  = 2'd0,
    KIND_INT   = 2'd1,
    KIND_FIXED = 2'd2,
    KIND_ALT   = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MRD,
    ST_MCMP,
    ST_FRD,
    ST_FDAT,
    ST_SRD,
    ST_SACC,
    ST_MUL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [4:0]  count;
    logic [7:0]  first;
    logic [3:0]  dlc;
    logic [28:0] ident;
    logic [1:0]  chan;
  } msg_entry_t;

  typedef struct packed {
    logic [31:0] scale;
    logic [31:0] offs;
    logic [1:0]  kind;
    logic [4:0]  count;
    logic [7:0]  first;
  } fld_entry_t;

  // count limited to MAX_LINKS and to lim
  function automatic logic [6:0] clamp_links(input logic [4:0] n, input logic [6:0] lim);
    logic [6:0] r;
    r = {2'b00, n};
    if (r > 7'(MAX_LINKS)) r = 7'(MAX_LINKS);
    if (r > lim) r = lim;
    return r;
  endfunction

  // one bit slice: byte, right shift, mask, left shift, 32-bit result
  function automatic logic [31:0] slice_bits(input logic [63:0] pl, input logic [18:0] w);
    logic [7:0] b;
    logic [7:0] v;
    b = pl[8*w[2:0] +: 8];
    v = (b >> w[5:3]) & w[13:6];
    return {24'd0, v} << w[18:14];
  endfunction

endpackage

// ----- rtl/csd_ram.sv -----
// ----------------------------------------------------------------------------
// csd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module csd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/can_signal_decoder_top.sv -----
// ----------------------------------------------------------------------------
// can_signal_decoder_top
// CAN frame to signal decoder driven by message, field and slice tables.
// ----------------------------------------------------------------------------
// Input words with tuser = 0 are frames; tuser 1..3 load a message, field or
// slice table entry in the cycle they are taken. A frame is matched against
// the first min(message_count, 64) message entries, one entry at a time (RAM
// read, then compare), up to the first hit. Each field of a hit then needs a
// descriptor read, one slice RAM read and OR per slice and a multiply for its
// result, plus any wait on the output. A miss or a message without fields
// gives one word. The input is taken only between frames; a finished result
// held in the output register does not block the next word.
// Tables are undefined until loaded; message_count resets to 0.
// ----------------------------------------------------------------------------
module can_signal_decoder_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [6:0]            cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // tdata, low bit up: entry_index 8, bus_channel 2, frame_id 29, frame_length 4,
  // payload 64, first_link 8, link_count 5, field_kind 2, offset 32,
  // scale_fixed 32, slice_word 19, zero fill 3
  input  logic [csd_pkg::IN_W-1:0]  s_tdata,
  // tuser: mode 2
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // tdata, low bit up: message_index 6, field_number 4, value 64, zero fill 6
  output logic [csd_pkg::OUT_W-1:0] m_tdata,
  // tuser, low bit up: matched 1, field_present 1, value_kind 2
  output logic [3:0]            m_tuser,
  output logic                  m_tlast
);

  import csd_pkg::*;

  // input word fields
  logic [7:0]  in_ei;
  logic [1:0]  in_chan;
  logic [28:0] in_id;
  logic [3:0]  in_dlc;
  logic [63:0] in_pl;
  logic [7:0]  in_first;
  logic [4:0]  in_cnt;
  logic [1:0]  in_kind;
  logic [31:0] in_off;
  logic [31:0] in_scl;
  logic [18:0] in_sw;

  assign in_ei    = s_tdata[7:0];
  assign in_chan  = s_tdata[9:8];
  assign in_id    = s_tdata[38:10];
  assign in_dlc   = s_tdata[42:39];
  assign in_pl    = s_tdata[106:43];
  assign in_first = s_tdata[114:107];
  assign in_cnt   = s_tdata[119:115];
  assign in_kind  = s_tdata[121:120];
  assign in_off   = s_tdata[153:122];
  assign in_scl   = s_tdata[185:154];
  assign in_sw    = s_tdata[204:186];

  state_t state, state_next;
  logic   s_acc;
  assign s_tready = (state == ST_IDLE);
  assign s_acc    = s_tvalid && s_tready;

  logic [6:0] message_count;

  // frame context
  logic [1:0]        fr_chan;
  logic [28:0]       fr_id;
  logic [3:0]        fr_dlc;
  logic [63:0]       fr_pl;
  logic [MSG_CW-1:0] limit;
  logic [MSG_CW-1:0] mi;
  logic [FLD_AW-1:0] fptr;
  logic [6:0]        nf;
  logic [6:0]        fcnt;
  logic [SLC_AW-1:0] sptr;
  logic [6:0]        sn;
  logic [6:0]        scnt;
  logic [1:0]        f_kind;
  logic [31:0]       f_off;
  logic [31:0]       f_scl;
  logic [31:0]       acc;
  logic [63:0]       prod;
  logic              res_field;   // pending word is a decoded field
  logic              res_matched;
  logic              out_free;

  assign out_free = !m_tvalid || m_tready;

  // table RAMs
  msg_entry_t msg_wd, msg_rd;
  fld_entry_t fld_wd, fld_rd;
  logic [SLC_W-1:0] slc_rd;
  logic msg_we, fld_we, slc_we;
  logic [MSG_AW-1:0] msg_ra;

  assign msg_wd = '{count: in_cnt, first: in_first, dlc: in_dlc, ident: in_id,
                    chan: in_chan};
  assign fld_wd = '{scale: in_scl, offs: in_off, kind: in_kind, count: in_cnt,
                    first: in_first};
  assign msg_we = s_acc && s_tuser == MODE_MSG &&
                  {3'b000, in_ei} < 11'(MESSAGE_ENTRIES);
  assign fld_we = s_acc && s_tuser == MODE_FIELD &&
                  {3'b000, in_ei} < 11'(FIELD_ENTRIES);
  assign slc_we = s_acc && s_tuser == MODE_SLICE &&
                  {3'b000, in_ei} < 11'(SLICE_ENTRIES);
  assign msg_ra = mi[MSG_AW-1:0];

  csd_ram #(.WIDTH(MSG_W), .DEPTH(MESSAGE_ENTRIES)) u_msg_ram (
    .clk(clk), .we(msg_we), .waddr(MSG_AW'(in_ei)), .wdata(msg_wd),
    .raddr(msg_ra), .rdata(msg_rd)
  );

  csd_ram #(.WIDTH(FLD_W), .DEPTH(FIELD_ENTRIES)) u_fld_ram (
    .clk(clk), .we(fld_we), .waddr(FLD_AW'(in_ei)), .wdata(fld_wd),
    .raddr(fptr), .rdata(fld_rd)
  );

  csd_ram #(.WIDTH(SLC_W), .DEPTH(SLICE_ENTRIES)) u_slc_ram (
    .clk(clk), .we(slc_we), .waddr(SLC_AW'(in_ei)), .wdata(in_sw),
    .raddr(sptr), .rdata(slc_rd)
  );

  // entry compare
  logic hit;
  assign hit = msg_rd.chan == fr_chan && msg_rd.ident == fr_id &&
               msg_rd.dlc == fr_dlc;

  logic [6:0] nf_hit;
  logic [6:0] sn_new;
  assign nf_hit = clamp_links(msg_rd.count, 7'(RESULT_LIMIT));
  assign sn_new = clamp_links(fld_rd.count, 7'(MAX_LINKS));

  logic [MSG_CW-1:0] limit_new;
  assign limit_new = ({4'd0, message_count} > 11'(MESSAGE_ENTRIES)) ?
                     MSG_CW'(MESSAGE_ENTRIES) : MSG_CW'(message_count);

  // result value
  logic [64:0] sum;
  logic [63:0] val_fix;
  logic [31:0] val_int;
  logic [63:0] res_val;
  logic [1:0]  res_kind;

  assign sum     = {prod[63], prod} + {{33{f_off[31]}}, f_off};
  assign val_fix = (sum[64] != sum[63]) ?
                   (sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : sum[63:0];
  assign val_int = acc + f_off;

  always_comb begin
    case (f_kind)
      KIND_INT: begin
        res_kind = KIND_INT;
        res_val  = {{32{val_int[31]}}, val_int};
      end
      KIND_FIXED: begin
        res_kind = KIND_FIXED;
        res_val  = val_fix;
      end
      default: begin
        res_kind = KIND_BOOL;
        res_val  = {63'd0, acc != 32'd0};
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_acc && s_tuser == MODE_FRAME) begin
          state_next = (limit_new == '0) ? ST_EMIT : ST_MRD;
        end
      end
      ST_MRD:  state_next = ST_MCMP;
      ST_MCMP: begin
        if (hit) begin
          state_next = (nf_hit == 7'd0) ? ST_EMIT : ST_FRD;
        end else if (mi + 1'b1 == limit) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_MRD;
        end
      end
      ST_FRD:  state_next = ST_FDAT;
      ST_FDAT: state_next = (sn_new == 7'd0) ? ST_MUL : ST_SRD;
      ST_SRD:  state_next = ST_SACC;
      ST_SACC: state_next = (scnt + 7'd1 == sn) ? ST_MUL : ST_SRD;
      ST_MUL:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = (res_field && fcnt + 7'd1 != nf) ? ST_FRD : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      message_count <= 7'd0;
    end else if (cfg_we) begin
      message_count <= cfg_wdata;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        fr_chan     <= in_chan;
        fr_id       <= in_id;
        fr_dlc      <= in_dlc;
        fr_pl       <= in_pl;
        limit       <= limit_new;
        mi          <= '0;
        res_field   <= 1'b0;
        res_matched <= 1'b0;
      end
      ST_MCMP: begin
        if (hit) begin
          res_matched <= 1'b1;
          res_field   <= (nf_hit != 7'd0);
          nf          <= nf_hit;
          fcnt        <= 7'd0;
          fptr        <= FLD_AW'(msg_rd.first % FIELD_ENTRIES);
        end else begin
          mi <= mi + 1'b1;
        end
      end
      ST_FDAT: begin
        f_kind <= fld_rd.kind;
        f_off  <= fld_rd.offs;
        f_scl  <= fld_rd.scale;
        sptr   <= SLC_AW'(fld_rd.first % SLICE_ENTRIES);
        sn     <= sn_new;
        scnt   <= 7'd0;
        acc    <= 32'd0;
      end
      ST_SACC: begin
        acc  <= acc | slice_bits(fr_pl, slc_rd);
        scnt <= scnt + 7'd1;
        sptr <= (sptr == SLC_AW'(SLICE_ENTRIES - 1)) ? '0 : sptr + 1'b1;
      end
      ST_MUL: begin
        prod <= 64'($signed(acc) * $signed(f_scl));
      end
      ST_EMIT: begin
        if (out_free) begin
          fcnt <= fcnt + 7'd1;
          fptr <= (fptr == FLD_AW'(FIELD_ENTRIES - 1)) ? '0 : fptr + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      m_tlast <= !res_field || (fcnt + 7'd1 == nf);
      m_tuser <= {res_field ? res_kind : 2'd0, res_field, res_matched};
      m_tdata <= {6'd0, res_field ? res_val : 64'd0,
                  res_field ? 4'(fcnt) : 4'd0,
                  res_matched ? 6'(mi) : 6'd0};
    end
  end

  // a miss or an empty message is a single word
  a_miss_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast)
    else $error("miss word without last");

  a_absent_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> m_tlast && m_tuser[3:2] == 2'd0)
    else $error("word without field not final");

  a_reset_quiet: assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");

endmodule

// ----- bench/can_signal_decoder_top_tb.sv -----
// ----------------------------------------------------------------------------
// can_signal_decoder_top_tb
// Self-checking bench for the CAN signal decoder. The linked part of each
// table is loaded first and random links stay inside it, so no frame ever
// reads an unwritten entry. Then directed frames exercise miss, empty
// message, link clamping and index wrap. Then random frames and table
// rewrites run under several message_count settings, with random gaps on
// both stream sides. Each output word is checked against a local decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module can_signal_decoder_top_tb;
  import csd_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE     = 40;
  localparam int FILL_SPAN  = 64;    // entries loaded up front in the slice and field tables
  localparam int LINK_SPAN  = 48;    // random first links, so 16 links stay in the fill

  typedef struct {
    mode_t       mode;
    logic [7:0]  entry;
    logic [1:0]  chan;
    logic [28:0] ident;
    logic [3:0]  dlc;
    logic [63:0] payload;
    logic [7:0]  first;
    logic [4:0]  count;
    kind_t       kind;
    logic [31:0] offs;
    logic [31:0] scale;
    logic [18:0] slice;
  } can_word_t;

  typedef struct {
    logic        matched;
    logic [5:0]  msg_idx;
    logic [3:0]  field_num;
    logic        present;
    logic [1:0]  vkind;
    logic [63:0] value;
    logic        last;
  } signal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [6:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic [3:0] m_tuser;
  logic m_tlast;

  // local copy of the decoder state
  logic [1:0]  msg_chan [MESSAGE_ENTRIES];
  logic [28:0] msg_ident[MESSAGE_ENTRIES];
  logic [3:0]  msg_dlc  [MESSAGE_ENTRIES];
  logic [7:0]  msg_first[MESSAGE_ENTRIES];
  logic [4:0]  msg_count[MESSAGE_ENTRIES];
  logic [7:0]  fld_first[FIELD_ENTRIES];
  logic [4:0]  fld_count[FIELD_ENTRIES];
  kind_t       fld_kind [FIELD_ENTRIES];
  logic [31:0] fld_offs [FIELD_ENTRIES];
  logic [31:0] fld_scale[FIELD_ENTRIES];
  logic [18:0] slc_word [SLICE_ENTRIES];
  logic [6:0]  msg_search_len = '0;

  signal_t expected_signals[$];
  int  errors = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;  // no gaps on either side while set

  can_signal_decoder_top DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] gather_slices(logic [63:0] pl, logic [7:0] first,
                                                logic [4:0] cnt);
    logic [31:0] acc;
    logic [7:0]  sidx;
    logic [18:0] w;
    logic [7:0]  b;
    int n;
    acc = '0;
    n = (cnt > MAX_LINKS) ? MAX_LINKS : cnt;
    for (int i = 0; i < n; i++) begin
      sidx = first + 8'(i);  // wraps with the 256-entry table
      w = slc_word[sidx];
      b = pl[8*w[2:0] +: 8];
      acc |= 32'((b >> w[5:3]) & w[13:6]) << w[18:14];
    end
    return acc;
  endfunction

  // apply a word to the local tables; a frame queues its expected signals
  task automatic decode_word(can_word_t c);
    int lim, hit, nf;
    logic [7:0] fi;
    logic [31:0] raw;
    longint prod, add, sum;
    signal_t r;
    case (c.mode)
      MODE_MSG: if (c.entry < MESSAGE_ENTRIES) begin
        msg_chan[c.entry] = c.chan;   msg_ident[c.entry] = c.ident;
        msg_dlc[c.entry] = c.dlc;     msg_first[c.entry] = c.first;
        msg_count[c.entry] = c.count;
      end
      MODE_FIELD: begin
        fld_first[c.entry] = c.first; fld_count[c.entry] = c.count;
        fld_kind[c.entry] = c.kind;   fld_offs[c.entry] = c.offs;
        fld_scale[c.entry] = c.scale;
      end
      MODE_SLICE: slc_word[c.entry] = c.slice;
      default: begin
        lim = (msg_search_len > MESSAGE_ENTRIES) ? MESSAGE_ENTRIES : msg_search_len;
        hit = -1;
        for (int m = 0; m < lim && hit < 0; m++)
          if (msg_chan[m] == c.chan && msg_ident[m] == c.ident && msg_dlc[m] == c.dlc)
            hit = m;
        r = '{default: '0};
        r.last = 1'b1;
        if (hit < 0) begin
          expected_signals.push_back(r);
        end else begin
          r.matched = 1'b1;
          r.msg_idx = 6'(hit);
          nf = (msg_count[hit] > RESULT_LIMIT) ? RESULT_LIMIT : msg_count[hit];
          if (nf == 0) expected_signals.push_back(r);
          for (int i = 0; i < nf; i++) begin
            fi = msg_first[hit] + 8'(i);
            raw = gather_slices(c.payload, fld_first[fi], fld_count[fi]);
            r.field_num = 4'(i);
            r.present = 1'b1;
            r.last = (i == nf - 1);
            case (fld_kind[fi])
              KIND_INT: begin
                r.vkind = KIND_INT;
                r.value = 64'(signed'(raw + fld_offs[fi]));
              end
              KIND_FIXED: begin
                prod = longint'(signed'(raw)) * longint'(signed'(fld_scale[fi]));
                add = longint'(signed'(fld_offs[fi]));
                if (add > 0 && prod > 64'sh7fffffffffffffff - add)
                  sum = 64'sh7fffffffffffffff;
                else if (add < 0 && prod < -64'sh7fffffffffffffff - 1 - add)
                  sum = -64'sh7fffffffffffffff - 1;
                else
                  sum = prod + add;
                r.vkind = KIND_FIXED;
                r.value = sum;
              end
              default: begin  // boolean and the spare kind
                r.vkind = KIND_BOOL;
                r.value = {63'd0, raw != 32'd0};
              end
            endcase
            expected_signals.push_back(r);
          end
        end
      end
    endcase
  endtask

  // send one word; leaves tvalid high after the accepting edge, so the caller
  // either sends again or lowers it in the same step
  task automatic send_word(can_word_t c);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c.mode;
    s_tdata  <= {3'b000, c.slice, c.scale, c.offs, c.kind, c.count, c.first,
                 c.payload, c.dlc, c.ident, c.chan, c.entry};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    decode_word(c);
  endtask

  // written only with the decoder idle
  task automatic set_search_len(logic [6:0] n);
    s_tvalid <= 1'b0;
    while (expected_signals.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
    msg_search_len = n;
  endtask

  function automatic can_word_t random_word(mode_t m);
    can_word_t c;
    c.mode = m;
    c.entry = 8'($urandom);
    c.chan = 2'($urandom);
    // small identifier set so entries collide and shadow each other
    c.ident = ($urandom_range(0, 3) == 0) ? 29'($urandom) : 29'($urandom_range(16, 40));
    c.dlc = 4'($urandom);
    c.payload = {$urandom, $urandom};
    c.first = 8'($urandom_range(0, LINK_SPAN - 1));
    c.count = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 4));
    c.kind = kind_t'(2'($urandom));
    c.offs = $urandom;
    c.scale = $urandom;
    c.slice = 19'($urandom);
    return c;
  endfunction

  // the low entries of every table are written once; random links never leave them
  task automatic test_table_fill();
    can_word_t c;
    for (int i = 0; i < FILL_SPAN; i++) begin
      c = random_word(MODE_SLICE); c.entry = 8'(i); send_word(c);
    end
    for (int i = 0; i < FILL_SPAN; i++) begin
      c = random_word(MODE_FIELD); c.entry = 8'(i); send_word(c);
    end
    for (int i = 0; i < MESSAGE_ENTRIES; i++) begin
      c = random_word(MODE_MSG); c.entry = 8'(i); send_word(c);
    end
  endtask

  task automatic test_directed();
    can_word_t c;
    set_search_len(7'd0);  // nothing searched: always a miss
    c = random_word(MODE_FRAME); send_word(c);
    set_search_len(7'd127);  // beyond the table, search clamps
    // empty message at entry 0
    c = random_word(MODE_MSG);
    c.entry = 0; c.chan = 0; c.ident = 0; c.dlc = 0; c.count = 0;
    send_word(c);
    // entry 63, extreme key, field count over the limit, field index wraps
    c.entry = 63; c.chan = 2'd3; c.ident = '1; c.dlc = 4'hf; c.first = 8'd250;
    c.count = 5'd31;
    send_word(c);
    // out of range entry: ignored
    c.entry = 8'd200; c.chan = 2'd1; c.ident = 29'd5; c.dlc = 4'd3; c.count = 5'd1;
    send_word(c);
    // field 255: slice count over the limit, slice index wraps, extreme fixed
    c = random_word(MODE_FIELD);
    c.entry = 8'd255; c.first = 8'd250; c.count = 5'd31; c.kind = KIND_FIXED;
    c.offs = 32'h7fffffff; c.scale = 32'h80000000;
    send_word(c);
    c.entry = 8'd250; c.count = 5'd2; c.kind = KIND_INT; c.offs = 32'h80000000;
    send_word(c);
    c.entry = 8'd251; c.kind = KIND_ALT; send_word(c);
    c.entry = 8'd252; c.kind = KIND_BOOL; send_word(c);
    c.entry = 8'd253; send_word(c);
    c.entry = 8'd254; send_word(c);
    // top slices reached through the wrap
    for (int e = 250; e < 255; e++) begin
      c = random_word(MODE_SLICE); c.entry = 8'(e); send_word(c);
    end
    c = random_word(MODE_SLICE);
    c.entry = 8'd255; c.slice = '1; send_word(c);
    c.entry = 8'd0; c.slice = '0; send_word(c);
    for (int p = 0; p < 3; p++) begin
      c = random_word(MODE_FRAME);
      c.chan = 0; c.ident = 0; c.dlc = 0;
      send_word(c);
      c.chan = 2'd3; c.ident = '1; c.dlc = 4'hf;
      c.payload = (p == 0) ? 64'd0 : (p == 1) ? '1 : c.payload;
      send_word(c);
      c.chan = 2'd1; c.ident = 29'd5; c.dlc = 4'd3;
      send_word(c);
    end
  endtask

  task automatic test_random(logic [6:0] search_len, int n_words);
    can_word_t c;
    int pick, lim, mi;
    set_search_len(search_len);
    lim = (search_len > MESSAGE_ENTRIES) ? MESSAGE_ENTRIES : search_len;
    for (int k = 0; k < n_words; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        c = random_word(mode_t'(2'($urandom_range(1, 3))));
      end else begin
        c = random_word(MODE_FRAME);
        if (pick < 80 && lim > 0) begin  // well-formed: key of a searched entry
          mi = $urandom_range(0, lim - 1);
          c.chan = msg_chan[mi]; c.ident = msg_ident[mi]; c.dlc = msg_dlc[mi];
        end
      end
      send_word(c);
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  // output side: random ready gaps
  initial begin
    int gap;
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    signal_t e;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("can_signal_decoder_top_tb NOT OK");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        if (expected_signals.size() == 0) begin
          report_mismatch("unexpected word", m_tdata[63:0], '0);
        end else begin
          e = expected_signals.pop_front();
          if (m_tuser[0] !== e.matched) report_mismatch("matched", m_tuser[0], e.matched);
          if (m_tdata[5:0] !== e.msg_idx) report_mismatch("msg_idx", m_tdata[5:0], e.msg_idx);
          if (m_tdata[9:6] !== e.field_num)
            report_mismatch("field_num", m_tdata[9:6], e.field_num);
          if (m_tuser[1] !== e.present) report_mismatch("present", m_tuser[1], e.present);
          if (m_tuser[3:2] !== e.vkind) report_mismatch("kind", m_tuser[3:2], e.vkind);
          if (m_tdata[73:10] !== e.value) report_mismatch("value", m_tdata[73:10], e.value);
          if (m_tlast !== e.last) report_mismatch("last", m_tlast, e.last);
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_table_fill();
    test_directed();
    test_random(7'd64, 80);
    quiet = 1'b1;
    test_random(7'd1, 40);
    quiet = 1'b0;
    test_random(7'($urandom_range(2, 63)), 80);
    test_random(7'd127, 50);
    s_tvalid <= 1'b0;
    while (expected_signals.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0)
      $display("can_signal_decoder_top_tb OK");
    else
      $display("can_signal_decoder_top_tb NOT OK");
    $finish;
  end

endmodule
